[rtl/cpcr_pkg.sv]
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types and constants for the circle pair collision unit
// Field clamp reset values, pipeline step counts and the pair record.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    localparam int unsigned CfgIndexWidth = 8;
    localparam int unsigned FieldWidth    = 12;
    localparam logic [FieldWidth-1:0] FieldWidthReset  = 12'd1280;
    localparam logic [FieldWidth-1:0] FieldHeightReset = 12'd720;

    // Square root: one result bit per stage, 17 bits cover a 34-bit sum.
    localparam int unsigned SqrtSteps = 17;
    // Normal division: quotient never exceeds 2^14, so 15 bits.
    localparam int unsigned DivSteps  = 15;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_FIELD_WIDTH  = 8'd0,
        CFG_FIELD_HEIGHT = 8'd1
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]        p1x;
        logic [15:0]        p1y;
        logic signed [15:0] v1x;
        logic signed [15:0] v1y;
        logic [7:0]         r1;
        logic [15:0]        p2x;
        logic [15:0]        p2y;
        logic signed [15:0] v2x;
        logic signed [15:0] v2y;
        logic [7:0]         r2;
    } pair_t;

endpackage

[rtl/circle_pair_collision_resolve_unit.sv]
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_unit: equal-mass circle collision resolver
// Finds overlap, exchanges normal velocity and pushes both circles apart.
// ----------------------------------------------------------------------------
// Pipeline: 40 register stages from input accept to result valid (2 front,
// 17 square-root, 1 overlap, 15 divide, 5 back).
// Throughput: one item per cycle; the whole pipeline holds while the result
// register is full and m_ready is low.
// Reset: clears all valid bits and loads field size 1280 x 720.
module circle_pair_collision_resolve_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cpcr_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [cpcr_pkg::FieldWidth-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [15:0]                          s_first_pos_x,
    input  logic [15:0]                          s_first_pos_y,
    input  logic signed [15:0]                   s_first_vel_x,
    input  logic signed [15:0]                   s_first_vel_y,
    input  logic [7:0]                           s_first_radius,
    input  logic [15:0]                          s_second_pos_x,
    input  logic [15:0]                          s_second_pos_y,
    input  logic signed [15:0]                   s_second_vel_x,
    input  logic signed [15:0]                   s_second_vel_y,
    input  logic [7:0]                           s_second_radius,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_new_first_pos_x,
    output logic [15:0]                          m_new_first_pos_y,
    output logic signed [15:0]                   m_new_first_vel_x,
    output logic signed [15:0]                   m_new_first_vel_y,
    output logic [15:0]                          m_new_second_pos_x,
    output logic [15:0]                          m_new_second_pos_y,
    output logic signed [15:0]                   m_new_second_vel_x,
    output logic signed [15:0]                   m_new_second_vel_y,
    output logic                                 m_collided
);

    localparam int unsigned SQ = cpcr_pkg::SqrtSteps;
    localparam int unsigned DV = cpcr_pkg::DivSteps;

    function automatic logic [15:0] clamp_axis(logic signed [20:0] pos, logic [7:0] r,
                                               logic [11:0] lim);
        logic signed [20:0] hi;
        logic signed [20:0] lo;
        logic signed [20:0] p;
        hi = ($signed(21'(lim)) - $signed(21'(r))) <<< 4;
        lo = $signed(21'(r)) <<< 4;
        p  = pos;
        if (p >= hi) p = hi - 21'sd16;
        if (p <= lo) p = lo + 21'sd16;
        return p[15:0];
    endfunction

    function automatic logic [15:0] sat16(logic signed [23:0] v);
        if (v > 24'sd32767)  return 16'h7FFF;
        if (v < -24'sd32768) return 16'h8000;
        return v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [11:0] field_width_reg;
    logic [11:0] field_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_width_reg  <= cpcr_pkg::FieldWidthReset;
            field_height_reg <= cpcr_pkg::FieldHeightReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cpcr_pkg::CFG_FIELD_WIDTH:  field_width_reg  <= cfg_data;
                cpcr_pkg::CFG_FIELD_HEIGHT: field_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances together; it holds only when the result waits.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // Stage A: capture, centre deltas
    // ------------------------------------------------------------------
    logic                  a_vld_reg;
    cpcr_pkg::pair_t       a_pair_reg;
    logic signed [16:0]    a_dx_reg, a_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en)  a_vld_reg <= s_valid;
        if (en) begin
            a_pair_reg <= '{p1x: s_first_pos_x, p1y: s_first_pos_y,
                            v1x: s_first_vel_x, v1y: s_first_vel_y, r1: s_first_radius,
                            p2x: s_second_pos_x, p2y: s_second_pos_y,
                            v2x: s_second_vel_x, v2y: s_second_vel_y, r2: s_second_radius};
            a_dx_reg <= $signed({1'b0, s_second_pos_x}) - $signed({1'b0, s_first_pos_x});
            a_dy_reg <= $signed({1'b0, s_second_pos_y}) - $signed({1'b0, s_first_pos_y});
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squares
    // ------------------------------------------------------------------
    logic                  b_vld_reg;
    cpcr_pkg::pair_t       b_pair_reg;
    logic signed [16:0]    b_dx_reg, b_dy_reg;
    logic [33:0]           b_sum_reg;
    logic signed [33:0]    sqx, sqy;

    assign sqx = a_dx_reg * a_dx_reg;
    assign sqy = a_dy_reg * a_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en)  b_vld_reg <= a_vld_reg;
        if (en) begin
            b_pair_reg <= a_pair_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_sum_reg  <= 34'(sqx) + 34'(sqy);
        end
    end

    // ------------------------------------------------------------------
    // Square root: one bit per stage
    // ------------------------------------------------------------------
    logic               sq_vld_reg  [SQ];
    cpcr_pkg::pair_t    sq_pair_reg [SQ];
    logic signed [16:0] sq_dx_reg   [SQ];
    logic signed [16:0] sq_dy_reg   [SQ];
    logic [33:0]        sq_rem_reg  [SQ];
    logic [33:0]        sq_res_reg  [SQ];

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [34:0] Bit = 35'd1 << (2 * (SQ - 1 - k));
        logic               vld_in;
        cpcr_pkg::pair_t    pair_in;
        logic signed [16:0] dx_in, dy_in;
        logic [33:0]        rem_in, res_in;
        logic [34:0]        trial;

        if (k == 0) begin : g_first
            assign vld_in  = b_vld_reg;
            assign pair_in = b_pair_reg;
            assign dx_in   = b_dx_reg;
            assign dy_in   = b_dy_reg;
            assign rem_in  = b_sum_reg;
            assign res_in  = '0;
        end else begin : g_next
            assign vld_in  = sq_vld_reg[k-1];
            assign pair_in = sq_pair_reg[k-1];
            assign dx_in   = sq_dx_reg[k-1];
            assign dy_in   = sq_dy_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign res_in  = sq_res_reg[k-1];
        end

        assign trial = 35'(res_in) + Bit;

        always_ff @(posedge aclk) begin
            if (!aresetn) sq_vld_reg[k] <= 1'b0;
            else if (en)  sq_vld_reg[k] <= vld_in;
            if (en) begin
                sq_pair_reg[k] <= pair_in;
                sq_dx_reg[k]   <= dx_in;
                sq_dy_reg[k]   <= dy_in;
                if (35'(rem_in) >= trial) begin
                    sq_rem_reg[k] <= 34'(35'(rem_in) - trial);
                    sq_res_reg[k] <= 34'((res_in >> 1) + Bit);
                end else begin
                    sq_rem_reg[k] <= rem_in;
                    sq_res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: overlap and divider setup
    // ------------------------------------------------------------------
    logic [16:0] dist_val;
    logic [16:0] mag_x, mag_y;
    assign dist_val = sq_res_reg[SQ-1][16:0];
    assign mag_x = sq_dx_reg[SQ-1][16] ? 17'(-sq_dx_reg[SQ-1]) : 17'(sq_dx_reg[SQ-1]);
    assign mag_y = sq_dy_reg[SQ-1][16] ? 17'(-sq_dy_reg[SQ-1]) : 17'(sq_dy_reg[SQ-1]);

    logic               e_vld_reg;
    cpcr_pkg::pair_t    e_pair_reg;
    logic [16:0]        e_dist_reg;
    logic signed [17:0] e_ovl_reg;
    logic               e_negx_reg, e_negy_reg;
    logic [30:0]        e_numx_reg, e_numy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) e_vld_reg <= 1'b0;
        else if (en)  e_vld_reg <= sq_vld_reg[SQ-1];
        if (en) begin
            e_pair_reg <= sq_pair_reg[SQ-1];
            e_dist_reg <= dist_val;
            e_ovl_reg  <= $signed({1'b0, (17'(sq_pair_reg[SQ-1].r1)
                                          + 17'(sq_pair_reg[SQ-1].r2)) << 4})
                          - $signed({1'b0, dist_val});
            e_negx_reg <= sq_dx_reg[SQ-1][16];
            e_negy_reg <= sq_dy_reg[SQ-1][16];
            e_numx_reg <= 31'(mag_x) << 14;
            e_numy_reg <= 31'(mag_y) << 14;
        end
    end

    // ------------------------------------------------------------------
    // Normal division: one quotient bit per stage, x and y side by side
    // ------------------------------------------------------------------
    logic               dv_vld_reg  [DV];
    cpcr_pkg::pair_t    dv_pair_reg [DV];
    logic [16:0]        dv_dist_reg [DV];
    logic signed [17:0] dv_ovl_reg  [DV];
    logic               dv_negx_reg [DV];
    logic               dv_negy_reg [DV];
    logic [30:0]        dv_numx_reg [DV];
    logic [30:0]        dv_numy_reg [DV];
    logic [DV-1:0]      dv_qx_reg   [DV];
    logic [DV-1:0]      dv_qy_reg   [DV];

    for (genvar k = 0; k < DV; k++) begin : g_div
        localparam int unsigned Sh = DV - 1 - k;
        localparam logic [DV-1:0] QBit = DV'(1) << Sh;
        logic               vld_in;
        cpcr_pkg::pair_t    pair_in;
        logic [16:0]        dist_in;
        logic signed [17:0] ovl_in;
        logic               negx_in, negy_in;
        logic [30:0]        numx_in, numy_in;
        logic [DV-1:0]      qx_in, qy_in;
        logic [31:0]        dsh;

        if (k == 0) begin : g_first
            assign vld_in  = e_vld_reg;
            assign pair_in = e_pair_reg;
            assign dist_in = e_dist_reg;
            assign ovl_in  = e_ovl_reg;
            assign negx_in = e_negx_reg;
            assign negy_in = e_negy_reg;
            assign numx_in = e_numx_reg;
            assign numy_in = e_numy_reg;
            assign qx_in   = '0;
            assign qy_in   = '0;
        end else begin : g_next
            assign vld_in  = dv_vld_reg[k-1];
            assign pair_in = dv_pair_reg[k-1];
            assign dist_in = dv_dist_reg[k-1];
            assign ovl_in  = dv_ovl_reg[k-1];
            assign negx_in = dv_negx_reg[k-1];
            assign negy_in = dv_negy_reg[k-1];
            assign numx_in = dv_numx_reg[k-1];
            assign numy_in = dv_numy_reg[k-1];
            assign qx_in   = dv_qx_reg[k-1];
            assign qy_in   = dv_qy_reg[k-1];
        end

        assign dsh = 32'(dist_in) << Sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_vld_reg[k] <= 1'b0;
            else if (en)  dv_vld_reg[k] <= vld_in;
            if (en) begin
                dv_pair_reg[k] <= pair_in;
                dv_dist_reg[k] <= dist_in;
                dv_ovl_reg[k]  <= ovl_in;
                dv_negx_reg[k] <= negx_in;
                dv_negy_reg[k] <= negy_in;
                if (32'(numx_in) >= dsh) begin
                    dv_numx_reg[k] <= 31'(32'(numx_in) - dsh);
                    dv_qx_reg[k]   <= qx_in | QBit;
                end else begin
                    dv_numx_reg[k] <= numx_in;
                    dv_qx_reg[k]   <= qx_in;
                end
                if (32'(numy_in) >= dsh) begin
                    dv_numy_reg[k] <= 31'(32'(numy_in) - dsh);
                    dv_qy_reg[k]   <= qy_in | QBit;
                end else begin
                    dv_numy_reg[k] <= numy_in;
                    dv_qy_reg[k]   <= qy_in;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: signed normal
    // ------------------------------------------------------------------
    logic               f_vld_reg;
    cpcr_pkg::pair_t    f_pair_reg;
    logic signed [17:0] f_ovl_reg;
    logic signed [15:0] f_nx_reg, f_ny_reg;
    logic signed [15:0] qx_s, qy_s;

    assign qx_s = $signed(16'(dv_qx_reg[DV-1]));
    assign qy_s = $signed(16'(dv_qy_reg[DV-1]));

    always_ff @(posedge aclk) begin
        if (!aresetn) f_vld_reg <= 1'b0;
        else if (en)  f_vld_reg <= dv_vld_reg[DV-1];
        if (en) begin
            f_pair_reg <= dv_pair_reg[DV-1];
            f_ovl_reg  <= dv_ovl_reg[DV-1];
            // coincident centres: zero normal
            if (dv_dist_reg[DV-1] == '0) begin
                f_nx_reg <= '0;
                f_ny_reg <= '0;
            end else begin
                f_nx_reg <= dv_negx_reg[DV-1] ? -qx_s : qx_s;
                f_ny_reg <= dv_negy_reg[DV-1] ? -qy_s : qy_s;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage G: normal products
    // ------------------------------------------------------------------
    logic               g_vld_reg;
    cpcr_pkg::pair_t    g_pair_reg;
    logic               g_hit_reg;
    logic signed [15:0] g_nx_reg, g_ny_reg;
    logic signed [32:0] g_mvx_reg, g_mvy_reg;
    logic signed [33:0] g_mox_reg, g_moy_reg;
    logic signed [16:0] rvx, rvy;

    assign rvx = 17'(f_pair_reg.v1x) - 17'(f_pair_reg.v2x);
    assign rvy = 17'(f_pair_reg.v1y) - 17'(f_pair_reg.v2y);

    always_ff @(posedge aclk) begin
        if (!aresetn) g_vld_reg <= 1'b0;
        else if (en)  g_vld_reg <= f_vld_reg;
        if (en) begin
            g_pair_reg <= f_pair_reg;
            g_hit_reg  <= !f_ovl_reg[17];
            g_nx_reg   <= f_nx_reg;
            g_ny_reg   <= f_ny_reg;
            g_mvx_reg  <= f_nx_reg * rvx;
            g_mvy_reg  <= f_ny_reg * rvy;
            g_mox_reg  <= f_nx_reg * f_ovl_reg;
            g_moy_reg  <= f_ny_reg * f_ovl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: relative speed, push offsets
    // ------------------------------------------------------------------
    logic               h_vld_reg;
    cpcr_pkg::pair_t    h_pair_reg;
    logic               h_hit_reg;
    logic signed [15:0] h_nx_reg, h_ny_reg;
    logic signed [33:0] h_speed_reg;
    logic signed [19:0] h_offx_reg, h_offy_reg;
    logic signed [34:0] rndx, rndy;

    assign rndx = (35'(g_mox_reg) + 35'sd16384) >>> 15;
    assign rndy = (35'(g_moy_reg) + 35'sd16384) >>> 15;

    always_ff @(posedge aclk) begin
        if (!aresetn) h_vld_reg <= 1'b0;
        else if (en)  h_vld_reg <= g_vld_reg;
        if (en) begin
            h_pair_reg  <= g_pair_reg;
            h_hit_reg   <= g_hit_reg;
            h_nx_reg    <= g_nx_reg;
            h_ny_reg    <= g_ny_reg;
            h_speed_reg <= 34'(g_mvx_reg) + 34'(g_mvy_reg);
            h_offx_reg  <= rndx[19:0];
            h_offy_reg  <= rndy[19:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage I: exchange products, pushed positions
    // ------------------------------------------------------------------
    logic               i_vld_reg;
    cpcr_pkg::pair_t    i_pair_reg;
    logic               i_hit_reg;
    logic               i_xchg_reg;
    logic signed [49:0] i_ex_reg, i_ey_reg;
    logic signed [20:0] i_p1x_reg, i_p1y_reg, i_p2x_reg, i_p2y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) i_vld_reg <= 1'b0;
        else if (en)  i_vld_reg <= h_vld_reg;
        if (en) begin
            i_pair_reg <= h_pair_reg;
            i_hit_reg  <= h_hit_reg;
            i_xchg_reg <= !h_speed_reg[33];
            i_ex_reg   <= h_speed_reg * h_nx_reg;
            i_ey_reg   <= h_speed_reg * h_ny_reg;
            i_p1x_reg  <= $signed(21'(h_pair_reg.p1x)) - 21'(h_offx_reg);
            i_p1y_reg  <= $signed(21'(h_pair_reg.p1y)) - 21'(h_offy_reg);
            i_p2x_reg  <= $signed(21'(h_pair_reg.p2x)) + 21'(h_offx_reg);
            i_p2y_reg  <= $signed(21'(h_pair_reg.p2y)) + 21'(h_offy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage J: velocity update, saturation, clamp; result register
    // ------------------------------------------------------------------
    logic signed [50:0] dvx_full, dvy_full;
    logic signed [23:0] dvx, dvy;
    logic signed [23:0] v1x_n, v1y_n, v2x_n, v2y_n;

    assign dvx_full = (51'(i_ex_reg) + 51'sd134217728) >>> 28;
    assign dvy_full = (51'(i_ey_reg) + 51'sd134217728) >>> 28;
    assign dvx = i_xchg_reg ? dvx_full[23:0] : '0;
    assign dvy = i_xchg_reg ? dvy_full[23:0] : '0;
    assign v1x_n = 24'(i_pair_reg.v1x) - dvx;
    assign v1y_n = 24'(i_pair_reg.v1y) - dvy;
    assign v2x_n = 24'(i_pair_reg.v2x) + dvx;
    assign v2y_n = 24'(i_pair_reg.v2y) + dvy;

    logic m_valid_reg;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= i_vld_reg;
        if (en) begin
            m_collided <= i_hit_reg;
            if (i_hit_reg) begin
                m_new_first_pos_x  <= clamp_axis(i_p1x_reg, i_pair_reg.r1, field_width_reg);
                m_new_first_pos_y  <= clamp_axis(i_p1y_reg, i_pair_reg.r1, field_height_reg);
                m_new_second_pos_x <= clamp_axis(i_p2x_reg, i_pair_reg.r2, field_width_reg);
                m_new_second_pos_y <= clamp_axis(i_p2y_reg, i_pair_reg.r2, field_height_reg);
                m_new_first_vel_x  <= sat16(v1x_n);
                m_new_first_vel_y  <= sat16(v1y_n);
                m_new_second_vel_x <= sat16(v2x_n);
                m_new_second_vel_y <= sat16(v2y_n);
            end else begin
                // no overlap: pass through
                m_new_first_pos_x  <= i_pair_reg.p1x;
                m_new_first_pos_y  <= i_pair_reg.p1y;
                m_new_second_pos_x <= i_pair_reg.p2x;
                m_new_second_pos_y <= i_pair_reg.p2y;
                m_new_first_vel_x  <= i_pair_reg.v1x;
                m_new_first_vel_y  <= i_pair_reg.v1y;
                m_new_second_vel_x <= i_pair_reg.v2x;
                m_new_second_vel_y <= i_pair_reg.v2y;
            end
        end
    end

endmodule

[rtl/cpcr_checker.sv]
// ----------------------------------------------------------------------------
// cpcr_checker: port-level checks for the circle pair collision unit
// Watches reset, flow control and clamp bounds on the result channel.
// ----------------------------------------------------------------------------
module cpcr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [15:0]                        m_new_first_pos_x,
    input logic [15:0]                        m_new_first_pos_y,
    input logic [15:0]                        m_new_second_pos_x,
    input logic [15:0]                        m_new_second_pos_y,
    input logic                               m_collided
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input side stalls only when a result is waiting
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow result flow");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_first_pos_x)
                                && $stable(m_collided))
        else $error("stalled result changed");

    // clamped centres always sit above the radius, so never at zero
    a_clamp_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_collided |-> m_new_first_pos_x >= 16'd1 && m_new_first_pos_y >= 16'd1
                                  && m_new_second_pos_x >= 16'd1
                                  && m_new_second_pos_y >= 16'd1)
        else $error("collided centre below clamp floor");

endmodule

bind circle_pair_collision_resolve_unit cpcr_checker u_cpcr_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_new_first_pos_x  (m_new_first_pos_x),
    .m_new_first_pos_y  (m_new_first_pos_y),
    .m_new_second_pos_x (m_new_second_pos_x),
    .m_new_second_pos_y (m_new_second_pos_y),
    .m_collided         (m_collided)
);
